FILE: hdl/obb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and constants of the oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int FieldW   = 63;
  localparam int NumAxes  = 15;
  localparam int NumFaces = 6;
  localparam int NumCross = 9;

  // pipeline register stages
  localparam int StgIn    = 0;
  localparam int StgProd  = 1;
  localparam int StgAxis  = 2;
  localparam int StgDot   = 3;
  localparam int StgAbs   = 4;
  localparam int StgScale = 5;
  localparam int StgPart  = 6;
  localparam int StgSep   = 7;
  localparam int StgOut   = 8;
  localparam int NumStages = 9;

  localparam logic ModeAll  = 1'b0;
  localparam logic ModeFace = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [FieldW-1:0] center_a;
    logic [FieldW-1:0] rot_a_row0;
    logic [FieldW-1:0] rot_a_row1;
    logic [FieldW-1:0] rot_a_row2;
    logic [FieldW-1:0] half_a;
    logic [FieldW-1:0] center_b;
    logic [FieldW-1:0] rot_b_row0;
    logic [FieldW-1:0] rot_b_row1;
    logic [FieldW-1:0] rot_b_row2;
    logic [FieldW-1:0] half_b;
  } obb_in_t;

  typedef struct packed {
    logic hit;
  } obb_out_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } obb_ctl_t;

endpackage

FILE: hdl/obb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_in_if / obb_out_if
// Valid/ready channels for box pairs and overlap results.
// ----------------------------------------------------------------------------
interface obb_in_if;
  logic             valid;
  logic             ready;
  obb_pkg::obb_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface obb_out_if;
  logic              valid;
  logic              ready;
  obb_pkg::obb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/oriented_box_overlap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_overlap_test
// Separating axis overlap test of two oriented boxes, one pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  in_i    | in  | mode, centers, rotation rows, half sizes | valid/ready
//  out_o   | out | hit                                      | valid/ready
//
// Nine register stages: one item enters per cycle while the output is not stalled,
// and its result is shown from the StgOut register; the axis multipliers set the depth.
// Reset clears the valid bits only; data registers carry no reset.
// Each stage holds while it is full and the stage after it cannot take it,
// so bubbles close up and input is taken until every stage is full.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  obb_in_if.sink    in_i,
  obb_out_if.source out_o
);

  localparam int C  = COORD_BITS;
  localparam int NS = obb_pkg::NumStages;

  logic [NS-1:0]     vld_q;
  obb_pkg::obb_ctl_t ctl;

  // a stage loads when empty or when its item moves on
  always_comb begin
    ctl.en[NS-1] = !vld_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) ctl.en[k] = !vld_q[k] || ctl.en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ctl.en[0]) vld_q[0] <= in_i.valid;
      for (int k = 1; k < NS; k++) begin
        if (ctl.en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_i.ready = ctl.en[obb_pkg::StgIn];

  logic signed [C:0]     ctr_delta [3];
  logic signed [C-1:0]   rows [obb_pkg::NumFaces][3];
  logic        [C-1:0]   hmag [obb_pkg::NumFaces];
  logic signed [2*C:0]   axis [obb_pkg::NumAxes][3];
  logic [obb_pkg::NumAxes-1:0] sep;

  obb_axis_gen #(.COORD_BITS(COORD_BITS)) u_gen (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .item_i (in_i.data),
    .dist_o (ctr_delta),
    .rows_o (rows),
    .hmag_o (hmag),
    .axis_o (axis)
  );

  for (genvar g = 0; g < obb_pkg::NumAxes; g++) begin : g_axis
    obb_axis_test #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_test (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .dist_i (ctr_delta),
      .rows_i (rows),
      .hmag_i (hmag),
      .axis_i (axis[g]),
      .sep_o  (sep[g])
    );
  end

  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl.en[obb_pkg::StgOut]) hit_q <= ~|sep;
  end

  assign out_o.valid    = vld_q[obb_pkg::StgOut];
  assign out_o.data.hit = hit_q;

  // input is refused only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q && !out_o.ready))
    else $error("input blocked with a free stage");

  // a stalled middle stage keeps its item
  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[obb_pkg::StgAbs] && !ctl.en[obb_pkg::StgAbs]) |=> vld_q[obb_pkg::StgAbs])
    else $error("stalled item lost");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !vld_q[obb_pkg::StgSep]) |=> !out_o.valid)
    else $error("result repeated");

endmodule

FILE: hdl/obb_axis_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_axis_gen
// Captures a box pair, unpacks it and forms the fifteen test axes.
// ----------------------------------------------------------------------------
module obb_axis_gen #(
  parameter int COORD_BITS = 21
) (
  input  logic               clk_i,
  input  obb_pkg::obb_ctl_t  ctl_i,
  input  obb_pkg::obb_in_t   item_i,
  output logic signed [COORD_BITS:0]     dist_o [3],
  output logic signed [COORD_BITS-1:0]   rows_o [obb_pkg::NumFaces][3],
  output logic        [COORD_BITS-1:0]   hmag_o [obb_pkg::NumFaces],
  output logic signed [2*COORD_BITS:0]   axis_o [obb_pkg::NumAxes][3]
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C;
  localparam int UW = 2 * C + 1;

  obb_pkg::obb_in_t raw_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgIn]) raw_q <= item_i;
  end

  function automatic logic signed [C-1:0] comp(input logic [obb_pkg::FieldW-1:0] f,
                                               input int k);
    return f[k*C +: C];
  endfunction

  logic signed [C-1:0] ca [3];
  logic signed [C-1:0] cb [3];
  logic signed [C-1:0] row_d [obb_pkg::NumFaces][3];
  logic signed [C-1:0] ha [3];
  logic signed [C-1:0] hb [3];
  logic        [C-1:0] hmag_d [obb_pkg::NumFaces];
  logic signed [DW-1:0] dist_d [3];
  logic signed [PW-1:0] pp_d [obb_pkg::NumCross][3];
  logic signed [PW-1:0] pn_d [obb_pkg::NumCross][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = comp(raw_q.center_a, k);
      cb[k] = comp(raw_q.center_b, k);
      ha[k] = comp(raw_q.half_a, k);
      hb[k] = comp(raw_q.half_b, k);
      row_d[0][k] = comp(raw_q.rot_a_row0, k);
      row_d[1][k] = comp(raw_q.rot_a_row1, k);
      row_d[2][k] = comp(raw_q.rot_a_row2, k);
      row_d[3][k] = comp(raw_q.rot_b_row0, k);
      row_d[4][k] = comp(raw_q.rot_b_row1, k);
      row_d[5][k] = comp(raw_q.rot_b_row2, k);
      dist_d[k] = DW'(cb[k]) - DW'(ca[k]);
      hmag_d[k]     = ha[k][C-1] ? C'(-ha[k]) : C'(ha[k]);
      hmag_d[k + 3] = hb[k][C-1] ? C'(-hb[k]) : C'(hb[k]);
    end
    // axis A_i x B_j, component k = a[k+1]*b[k+2] - a[k+2]*b[k+1]
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pp_d[i*3+j][k] = PW'(row_d[i][(k == 2) ? 0 : k + 1])
                         * PW'(row_d[j+3][(k == 0) ? 2 : k - 1]);
          pn_d[i*3+j][k] = PW'(row_d[i][(k == 0) ? 2 : k - 1])
                         * PW'(row_d[j+3][(k == 2) ? 0 : k + 1]);
        end
      end
    end
  end

  logic                 mode_q1;
  logic signed [C-1:0]  row_q1 [obb_pkg::NumFaces][3];
  logic        [C-1:0]  hmag_q1 [obb_pkg::NumFaces];
  logic signed [DW-1:0] dist_q1 [3];
  logic signed [PW-1:0] pp_q1 [obb_pkg::NumCross][3];
  logic signed [PW-1:0] pn_q1 [obb_pkg::NumCross][3];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgProd]) begin
      mode_q1 <= raw_q.mode;
      row_q1  <= row_d;
      hmag_q1 <= hmag_d;
      dist_q1 <= dist_d;
      pp_q1   <= pp_d;
      pn_q1   <= pn_d;
    end
  end

  logic signed [UW-1:0] axis_d [obb_pkg::NumAxes][3];

  // a zero axis never separates, so face-only mode clears the cross axes
  always_comb begin
    for (int a = 0; a < obb_pkg::NumFaces; a++) begin
      for (int k = 0; k < 3; k++) axis_d[a][k] = UW'(row_q1[a][k]);
    end
    for (int n = 0; n < obb_pkg::NumCross; n++) begin
      for (int k = 0; k < 3; k++) begin
        axis_d[obb_pkg::NumFaces+n][k] = (mode_q1 == obb_pkg::ModeFace) ? '0
                                       : UW'(pp_q1[n][k]) - UW'(pn_q1[n][k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgAxis]) begin
      rows_o <= row_q1;
      hmag_o <= hmag_q1;
      dist_o <= dist_q1;
      axis_o <= axis_d;
    end
  end

endmodule

FILE: hdl/obb_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_axis_test
// Projects the pair onto one axis and flags a separating axis.
// ----------------------------------------------------------------------------
module obb_axis_test #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  logic               clk_i,
  input  obb_pkg::obb_ctl_t  ctl_i,
  input  logic signed [COORD_BITS:0]     dist_i [3],
  input  logic signed [COORD_BITS-1:0]   rows_i [obb_pkg::NumFaces][3],
  input  logic        [COORD_BITS-1:0]   hmag_i [obb_pkg::NumFaces],
  input  logic signed [2*COORD_BITS:0]   axis_i [3],
  output logic                           sep_o
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int UW   = 2 * C + 1;
  localparam int DPW  = DW + UW;
  localparam int DSW  = DPW + 2;
  localparam int RPW  = C + UW;
  localparam int RSW  = RPW + 2;
  localparam int SPL  = (RSW + 1) / 2;
  localparam int HIW  = RSW - SPL;
  localparam int EW   = RSW + C + 3;
  localparam int DSH  = DSW + FRAC_BITS;
  localparam int CW   = (EW > DSH) ? EW : DSH;
  localparam int NF   = obb_pkg::NumFaces;

  // products with the axis
  logic signed [DPW-1:0] dp_q [3];
  logic signed [RPW-1:0] rp_q [NF][3];
  logic        [C-1:0]   hmag_q3 [NF];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgDot]) begin
      for (int k = 0; k < 3; k++) begin
        dp_q[k] <= DPW'(dist_i[k]) * DPW'(axis_i[k]);
        for (int r = 0; r < NF; r++) rp_q[r][k] <= RPW'(rows_i[r][k]) * RPW'(axis_i[k]);
      end
      hmag_q3 <= hmag_i;
    end
  end

  // magnitudes of the dot products
  logic signed [DSW-1:0] dsum;
  logic signed [RSW-1:0] rsum [NF];
  logic        [DSW-1:0] dabs_d;
  logic        [RSW-1:0] rabs_d [NF];

  always_comb begin
    dsum   = DSW'(dp_q[0]) + DSW'(dp_q[1]) + DSW'(dp_q[2]);
    dabs_d = dsum[DSW-1] ? DSW'(-dsum) : DSW'(dsum);
    for (int r = 0; r < NF; r++) begin
      rsum[r]   = RSW'(rp_q[r][0]) + RSW'(rp_q[r][1]) + RSW'(rp_q[r][2]);
      rabs_d[r] = rsum[r][RSW-1] ? RSW'(-rsum[r]) : RSW'(rsum[r]);
    end
  end

  logic [DSW-1:0] dabs_q;
  logic [RSW-1:0] rabs_q [NF];
  logic [C-1:0]   hmag_q4 [NF];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgAbs]) begin
      dabs_q  <= dabs_d;
      rabs_q  <= rabs_d;
      hmag_q4 <= hmag_q3;
    end
  end

  // scale by half sizes, split into two narrower products
  logic [SPL+C-1:0] ml_q [NF];
  logic [HIW+C-1:0] mh_q [NF];
  logic [DSW-1:0]   dabs_q5;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgScale]) begin
      for (int r = 0; r < NF; r++) begin
        ml_q[r] <= (SPL+C)'(rabs_q[r][SPL-1:0]) * (SPL+C)'(hmag_q4[r]);
        mh_q[r] <= (HIW+C)'(rabs_q[r][RSW-1:SPL]) * (HIW+C)'(hmag_q4[r]);
      end
      dabs_q5 <= dabs_q;
    end
  end

  logic [EW-1:0] term [NF];
  logic [EW-1:0] part_d [3];

  always_comb begin
    for (int r = 0; r < NF; r++) term[r] = EW'(ml_q[r]) + (EW'(mh_q[r]) << SPL);
    for (int p = 0; p < 3; p++) part_d[p] = term[2*p] + term[2*p+1];
  end

  logic [EW-1:0]  part_q [3];
  logic [DSH-1:0] dsh_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgPart]) begin
      part_q <= part_d;
      dsh_q  <= DSH'(dabs_q5) << FRAC_BITS;
    end
  end

  logic [CW-1:0] ext;

  // touching counts as overlap: only a strictly larger distance separates
  always_comb ext = CW'(part_q[0]) + CW'(part_q[1]) + CW'(part_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[obb_pkg::StgSep]) sep_o <= CW'(dsh_q) > ext;
  end

endmodule
